@@ sv/mrc_pkg.sv @@
`default_nettype none

package mrc_pkg;

  typedef logic signed [15:0] sample_t;

  localparam int unsigned APB_ADDR_W = 5;

  localparam sample_t U8_SAMPLE_MAX = 16'sd255;

  typedef enum logic [2:0] {
    REG_DECODE_MODE    = 3'd0,
    REG_SIGNED_SAMPLES = 3'd1,
    REG_IMAGE_WIDTH    = 3'd2,
    REG_IMAGE_HEIGHT   = 3'd3,
    REG_CHANNEL_COUNT  = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ sv/mrc_line_buf.sv @@
`default_nettype none

module mrc_line_buf #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire mrc_pkg::sample_t  wr_data_i,
  output mrc_pkg::sample_t       rd_data_o
);
  import mrc_pkg::*;

  sample_t mem_q [DEPTH];
  sample_t rd_q;
  sample_t fwd_data_q;
  logic    fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // same-entry write in the read cycle: hand the new value over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i && wr_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

@@ sv/med_residual_codec.sv @@
// Pipeline: an accepted item and its line buffer read are registered in the prediction
// stage, then its result in the output register; a stalled output holds both stages.
// Throughput: one item per cycle unless stalled; one line buffer read and write each cycle.
// Reset: registers return to their defaults, position and neighbor samples clear;
// line buffer contents are not cleared, each entry is written before its value is used.
`default_nettype none

module med_residual_codec #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mrc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // sample_in
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [15:0]                     m_axis_tdata,  // value_out
  output logic                                 m_axis_tlast   // last_of_image
);
  import mrc_pkg::*;

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WLIM_W = COL_W + 1;
  localparam int unsigned CLIM_W = CH_W + 1;

  // registers
  logic        decode_q;
  logic        signed_q;
  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [2:0]  chans_q;
  logic        cfg_wr;
  logic        cfg_restart;
  cfg_reg_e    cfg_sel;

  // position
  logic [COL_W-1:0] col_q, col_d;
  logic [CH_W-1:0]  ch_q, ch_d;
  logic [15:0]      row_q, row_d;
  logic [WLIM_W-1:0] w_lim;
  logic [CLIM_W-1:0] c_lim;
  logic [15:0]       h_lim;
  logic              col_last, ch_last, row_last;
  logic [ADDR_W-1:0] cur_idx;

  // prediction stage
  logic              s1_valid_q;
  sample_t           s1_data_q;
  logic [CH_W-1:0]   s1_ch_q;
  logic [ADDR_W-1:0] s1_idx_q;
  logic              s1_col_nz_q;
  logic              s1_row_nz_q;
  logic              s1_last_q;
  logic              s1_adv;
  logic              accept;

  sample_t left_q [MAX_CHANNELS];
  sample_t ul_q   [MAX_CHANNELS];
  sample_t upper;

  sample_t           nb_a, nb_b, nb_c, lo, hi, pred, sample, result;
  logic signed [17:0] grad;
  logic signed [16:0] recon;

  logic    out_valid_q;
  sample_t out_data_q;
  logic    out_last_q;

  // configuration port
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_sel     = cfg_reg_e'(paddr[4:2]);
  // writes past the last register leave the image position alone
  assign cfg_restart = cfg_wr && (cfg_sel <= REG_CHANNEL_COUNT);

  always_comb begin
    case (cfg_sel)
      REG_DECODE_MODE:    prdata = {31'd0, decode_q};
      REG_SIGNED_SAMPLES: prdata = {31'd0, signed_q};
      REG_IMAGE_WIDTH:    prdata = {19'd0, width_q};
      REG_IMAGE_HEIGHT:   prdata = {16'd0, height_q};
      REG_CHANNEL_COUNT:  prdata = {29'd0, chans_q};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q <= 1'b0;
      signed_q <= 1'b0;
      width_q  <= 13'd1;
      height_q <= 16'd1;
      chans_q  <= 3'd1;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_DECODE_MODE:    decode_q <= pwdata[0];
        REG_SIGNED_SAMPLES: signed_q <= pwdata[0];
        REG_IMAGE_WIDTH:    width_q  <= pwdata[12:0];
        REG_IMAGE_HEIGHT:   height_q <= pwdata[15:0];
        REG_CHANNEL_COUNT:  chans_q  <= pwdata[2:0];
        default:            ;
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize saturates
  always_comb begin
    if (width_q == 13'd0) begin
      w_lim = WLIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_lim = WLIM_W'(MAX_WIDTH);
    end else begin
      w_lim = WLIM_W'(width_q);
    end
    if (chans_q == 3'd0) begin
      c_lim = CLIM_W'(1);
    end else if (32'(chans_q) > MAX_CHANNELS) begin
      c_lim = CLIM_W'(MAX_CHANNELS);
    end else begin
      c_lim = CLIM_W'(chans_q);
    end
    h_lim = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  assign col_last = (WLIM_W'(col_q) + WLIM_W'(1)) >= w_lim;
  assign ch_last  = (CLIM_W'(ch_q) + CLIM_W'(1)) >= c_lim;
  assign row_last = (17'(row_q) + 17'd1) >= 17'(h_lim);
  assign cur_idx  = ADDR_W'(32'(col_q) * MAX_CHANNELS + 32'(ch_q));

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_q;
    ch_d  = ch_q;
    row_d = row_q;
    if (ch_last) begin
      ch_d = '0;
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? 16'd0 : row_q + 16'd1;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else begin
      ch_d = ch_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      ch_q  <= '0;
      row_q <= '0;
    end else if (cfg_restart) begin
      col_q <= '0;
      ch_q  <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      ch_q  <= ch_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q   <= sample_t'(s_axis_tdata);
      s1_ch_q     <= ch_q;
      s1_idx_q    <= cur_idx;
      s1_col_nz_q <= (col_q != '0);
      s1_row_nz_q <= (row_q != 16'd0);
      s1_last_q   <= row_last && col_last && ch_last;
    end
  end

  mrc_line_buf #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (cur_idx),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (sample),
    .rd_data_o (upper)
  );

  // median edge detector and residual / reconstruction
  always_comb begin
    nb_a = s1_col_nz_q ? left_q[s1_ch_q] : '0;
    nb_b = s1_row_nz_q ? upper : '0;
    nb_c = (s1_col_nz_q && s1_row_nz_q) ? ul_q[s1_ch_q] : '0;
    lo   = (nb_a < nb_b) ? nb_a : nb_b;
    hi   = (nb_a < nb_b) ? nb_b : nb_a;
    grad = 18'(nb_a) + 18'(nb_b) - 18'(nb_c);
    if (nb_c >= hi) begin
      pred = lo;
    end else if (nb_c <= lo) begin
      pred = hi;
    end else begin
      pred = sample_t'(grad[15:0]);
    end
    recon = 17'(pred) + 17'(s1_data_q);
    if (decode_q) begin
      if (signed_q) begin
        sample = sample_t'(recon[15:0]);
      end else if (recon < 17'sd0) begin
        sample = '0;
      end else if (recon > 17'(U8_SAMPLE_MAX)) begin
        sample = U8_SAMPLE_MAX;
      end else begin
        sample = sample_t'(recon[15:0]);
      end
      result = sample;
    end else begin
      sample = signed_q ? s1_data_q : sample_t'({8'h00, s1_data_q[7:0]});
      result = sample - pred;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_q[i] <= '0;
        ul_q[i]   <= '0;
      end
    end else if (cfg_restart) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_q[i] <= '0;
        ul_q[i]   <= '0;
      end
    end else if (s1_adv) begin
      left_q[s1_ch_q] <= sample;
      ul_q[s1_ch_q]   <= nb_b;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= result;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ sim/med_residual_codec_tb.sv @@
`timescale 1ns / 1ps

module med_residual_codec_tb;
  import mrc_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int MAX_W          = 4096;
  localparam int MAX_CH         = 4;
  localparam int LINE_DEPTH     = MAX_W * MAX_CH;
  localparam int DRAIN_GAP      = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 88;
  localparam int NUM_DIR        = 39;

  // addresses past the last register, writes there are dropped
  localparam logic [2:0] REG_SPARE     = 3'd5;
  localparam logic [2:0] REG_SPARE_TOP = 3'd7;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    fixed;
    result_t res;
  } typed_want_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
    logic [15:0] smp;
    logic        fixed;
    logic [15:0] want;
    logic        want_last;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // sample_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;   // value_out
  logic                  m_axis_tlast;   // last_of_image

  // predictor copy of registers and neighbor state
  logic        cfg_decode;
  logic        cfg_signed;
  logic [12:0] cfg_width;
  logic [15:0] cfg_height;
  logic [2:0]  cfg_chans;
  int          line_mem [LINE_DEPTH];
  int          nb_left [MAX_CH];
  int          nb_upleft [MAX_CH];
  int          pos_col;
  int          pos_row;
  int          pos_chan;

  result_t     pending_values [$];
  typed_want_t fixed_wants [$];
  int          err_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_req;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{ROW_ITEM, 3'd0, 32'd0, 16'hFFFF, 1'b1, 16'h00FF, 1'b1},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7F80, 1'b1, 16'h0080, 1'b1},
    '{ROW_CFG, REG_SIGNED_SAMPLES, 32'd1, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h8000, 1'b1, 16'h8000, 1'b1},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_CFG, REG_DECODE_MODE, 32'd1, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h8001, 1'b1, 16'h8001, 1'b1},
    '{ROW_CFG, REG_SIGNED_SAMPLES, 32'd0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7FFF, 1'b1, 16'h00FF, 1'b1},
    // zero geometry behaves as a 1x1 single-channel image
    '{ROW_CFG, REG_IMAGE_WIDTH, 32'd0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_CHANNEL_COUNT, 32'd0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h0042, 1'b1, 16'h0042, 1'b1},
    // 2x2 image, two channels, 8-bit encode
    '{ROW_CFG, REG_DECODE_MODE, 32'd0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_IMAGE_WIDTH, 32'd2, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd2, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_CHANNEL_COUNT, 32'd2, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h00FF, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h0010, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h0080, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h0000, 1'b0, 16'h0, 1'b0},
    // ignored write: image position must carry on
    '{ROW_CFG, REG_SPARE, 32'hFFFF_FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h0001, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'hFF20, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h00FE, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7F00, 1'b0, 16'h0, 1'b0},
    // oversized geometry, 16-bit decode with wrap
    '{ROW_CFG, REG_SIGNED_SAMPLES, 32'd1, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_DECODE_MODE, 32'd1, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_IMAGE_WIDTH, 32'h1FFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'hFFFF, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_CHANNEL_COUNT, 32'd7, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7FFF, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7FFF, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h8000, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h0001, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h7FFF, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, REG_SPARE_TOP, 32'd0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 32'd0, 16'h8000, 1'b0, 16'h0, 1'b0}
  };

  med_residual_codec #(
    .MAX_WIDTH    (MAX_W),
    .MAX_CHANNELS (MAX_CH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void restart_image();
    pos_col  = 0;
    pos_row  = 0;
    pos_chan = 0;
    for (int i = 0; i < MAX_CH; i++) begin
      nb_left[i]   = 0;
      nb_upleft[i] = 0;
    end
  endfunction

  function automatic void cfg_apply(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      REG_DECODE_MODE:    cfg_decode = v[0];
      REG_SIGNED_SAMPLES: cfg_signed = v[0];
      REG_IMAGE_WIDTH:    cfg_width  = v[12:0];
      REG_IMAGE_HEIGHT:   cfg_height = v[15:0];
      REG_CHANNEL_COUNT:  cfg_chans  = v[2:0];
      default:            return;
    endcase
    restart_image();
  endfunction

  // MED prediction, residual or reconstruction, then advance the raster position
  function automatic result_t codec_model(input logic [15:0] din);
    int      w, h, cc, ch, col, idx;
    int      a, b, c, lo, hi, pred, smp;
    result_t r;
    w  = (cfg_width == 0) ? 1 : int'(cfg_width);
    h  = (cfg_height == 0) ? 1 : int'(cfg_height);
    cc = (cfg_chans == 0) ? 1 : int'(cfg_chans);
    if (w > MAX_W) w = MAX_W;
    if (cc > MAX_CH) cc = MAX_CH;
    ch  = pos_chan;
    col = pos_col;
    idx = col * MAX_CH + ch;
    a = (col > 0) ? nb_left[ch] : 0;
    b = (pos_row > 0) ? line_mem[idx] : 0;
    c = (col > 0 && pos_row > 0) ? nb_upleft[ch] : 0;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) pred = lo;
    else if (c <= lo) pred = hi;
    else pred = a + b - c;
    if (cfg_decode) begin
      smp = pred + int'($signed(din));
      if (cfg_signed) begin
        smp = int'($signed(smp[15:0]));
      end else if (smp < 0) begin
        smp = 0;
      end else if (smp > int'(U8_SAMPLE_MAX)) begin
        smp = int'(U8_SAMPLE_MAX);
      end
      r.value = smp[15:0];
    end else begin
      smp = cfg_signed ? int'($signed(din)) : int'(din[7:0]);
      r.value = 16'(smp - pred);
    end
    nb_upleft[ch] = b;
    nb_left[ch]   = smp;
    line_mem[idx] = smp;
    r.last = (pos_row + 1 >= h) && (col + 1 >= w) && (ch + 1 >= cc);
    if (ch + 1 >= cc) begin
      pos_chan = 0;
      if (col + 1 >= w) begin
        pos_col = 0;
        pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
      end else begin
        pos_col = col + 1;
      end
    end else begin
      pos_chan = ch + 1;
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4, 5:    return 16'(int'($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic [15:0] smp, input logic fixed, input result_t want);
    fixed_wants.push_back('{fixed, want});
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_apply(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver side: random stalls, or one long hold-off on request
  initial begin : rx_side
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t     want;
    result_t     pred;
    typed_want_t tw;
    logic        moved;
    moved = (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (psel && penable);
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_values.size() == 0) begin
        report_mismatch("unexpected output item", m_axis_tdata, 16'h0);
      end else begin
        want = pending_values.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("value_out", m_axis_tdata, want.value);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_of_image", 16'(m_axis_tlast), 16'(want.last));
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      pred = codec_model(s_axis_tdata);
      tw   = fixed_wants.pop_front();
      pending_values.push_back(tw.fixed ? tw.res : pred);
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [12:0] width;
    logic [15:0] height;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    err_count      = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cfg_decode     = 1'b0;
    cfg_signed     = 1'b0;
    cfg_width      = 13'd1;
    cfg_height     = 16'd1;
    cfg_chans      = 3'd1;
    restart_image();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_outputs();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        push_sample(dir_rows[i].smp, dir_rows[i].fixed,
                    '{dir_rows[i].want, dir_rows[i].want_last});
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_outputs();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case ($urandom_range(9))
        0:       width = 13'd0;
        1:       width = 13'd4096;
        2:       width = 13'($urandom_range(8191, 4097));
        default: width = 13'($urandom_range(6, 1));
      endcase
      case ($urandom_range(7))
        0:       height = 16'd0;
        1:       height = 16'hFFFF;
        default: height = 16'($urandom_range(4, 1));
      endcase
      cfg_write(REG_DECODE_MODE, 32'($urandom_range(1)));
      cfg_write(REG_SIGNED_SAMPLES, 32'($urandom_range(1)));
      cfg_write(REG_IMAGE_WIDTH, 32'(width));
      cfg_write(REG_IMAGE_HEIGHT, 32'(height));
      cfg_write(REG_CHANNEL_COUNT, 32'($urandom_range(7)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_req = 1'b1;
        if (ph == 5 && n == 44) drain_outputs();
        if (ph == 6 && n == 30) begin
          drain_outputs();
          cfg_write(REG_SPARE, $urandom);
        end
        push_sample(rand_sample(), 1'b0, '0);
      end
    end

    drain_outputs();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mrc_pkg.sv
sv/mrc_line_buf.sv
sv/med_residual_codec.sv
sim/med_residual_codec_tb.sv
